>>> design/lr_pkg.sv
// lr_pkg: shared types and constants for the line rasterizer
// holds the controller/datapath command and status structs and the register map
// no dependencies
`default_nettype none

package lr_pkg;

	// default parameter values
	localparam int unsigned MAX_DIM_DEFAULT    = 64;
	localparam int unsigned COORD_BITS_DEFAULT = 12;

	// configuration port
	localparam int unsigned CFG_BITS     = 7;
	localparam int unsigned CFG_IDX_BITS = 1;
	localparam int unsigned COLOR_BITS   = 32;

	localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_HEIGHT = 1'b1;

	// commands from controller to datapath
	typedef struct packed {
		logic load;       // take a new line transaction
		logic step;       // advance one bresenham step
		logic capture;    // hold the current point as pending pixel
		logic emit;       // move the pending pixel into the output register
		logic emit_last;  // mark the emitted pixel as last of the line
	} lr_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic reject;     // neither endpoint of the offered line is on the image
		logic on_image;   // current walk point is on the image
		logic at_end;     // current walk point equals the second endpoint
	} lr_status_t;

endpackage

`default_nettype wire

>>> design/lr_ctrl.sv
// lr_ctrl: controller state machine of the line rasterizer
// sequences load, walk and final flush, owns the handshake flags
// depends on lr_pkg
`default_nettype none

module lr_ctrl import lr_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	output logic            out_valid,
	input  wire logic       out_stall,
	input  wire lr_status_t status,
	output lr_cmd_t         cmd
);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_WALK  = 3'b010,
		ST_FLUSH = 3'b100
	} lr_state_t;

	lr_state_t state_q, state_d;
	logic      pend_valid_q, pend_valid_d;
	logic      out_valid_q, out_valid_d;
	logic      out_free;
	logic      need_emit;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;
	assign need_emit = status.on_image && pend_valid_q;

	// next state and command decode
	always_comb begin
		state_d      = state_q;
		pend_valid_d = pend_valid_q;
		cmd          = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && !status.reject) begin
					cmd.load     = 1'b1;
					pend_valid_d = 1'b0;
					state_d      = ST_WALK;
				end
			end
			ST_WALK: begin
				if (!status.on_image && pend_valid_q) begin
					// walked off the image after being on it: nothing more to plot
					state_d = ST_FLUSH;
				end else if (!need_emit || out_free) begin
					cmd.capture  = status.on_image;
					cmd.emit     = need_emit;
					pend_valid_d = pend_valid_q || status.on_image;
					if (status.at_end) begin
						state_d = ST_FLUSH;
					end else begin
						cmd.step = 1'b1;
					end
				end
			end
			ST_FLUSH: begin
				if (out_free) begin
					cmd.emit      = pend_valid_q;
					cmd.emit_last = 1'b1;
					pend_valid_d  = 1'b0;
					state_d       = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// output valid: set on emit, cleared once the sink takes the transaction
	always_comb begin
		if (cmd.emit) begin
			out_valid_d = 1'b1;
		end else if (!out_stall) begin
			out_valid_d = 1'b0;
		end else begin
			out_valid_d = out_valid_q;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			pend_valid_q <= pend_valid_d;
			out_valid_q  <= out_valid_d;
		end
	end

endmodule

`default_nettype wire

>>> design/lr_datapath.sv
// lr_datapath: bresenham walk registers, image bounds check and output register
// also holds the image size configuration registers
// depends on lr_pkg
`default_nettype none

module lr_datapath import lr_pkg::*; #(
	parameter int unsigned MAX_DIM    = MAX_DIM_DEFAULT,
	parameter int unsigned COORD_BITS = COORD_BITS_DEFAULT,
	localparam int unsigned PIX_BITS  = $clog2(MAX_DIM)
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [CFG_IDX_BITS-1:0]      cfg_addr,
	input  wire logic [CFG_BITS-1:0]          cfg_wdata,
	input  wire logic signed [COORD_BITS-1:0] start_x,
	input  wire logic signed [COORD_BITS-1:0] start_y,
	input  wire logic signed [COORD_BITS-1:0] end_x,
	input  wire logic signed [COORD_BITS-1:0] end_y,
	input  wire logic [COLOR_BITS-1:0]        line_color,
	input  wire lr_cmd_t                      cmd,
	output lr_status_t                        status,
	output logic [PIX_BITS-1:0]               pixel_x,
	output logic [PIX_BITS-1:0]               pixel_y,
	output logic [COLOR_BITS-1:0]             pixel_color,
	output logic                              last_pixel
);

	localparam int unsigned DIM_BITS = $clog2(MAX_DIM + 1);
	localparam int unsigned ERR_BITS = COORD_BITS + 2;

	// on-image test for one point against the effective image size
	function automatic logic in_image(
		input logic [COORD_BITS-1:0] px,
		input logic [COORD_BITS-1:0] py,
		input logic [DIM_BITS-1:0]   w,
		input logic [DIM_BITS-1:0]   h
	);
		logic [COORD_BITS-1:0] wx;
		logic [COORD_BITS-1:0] hx;
		wx = {{(COORD_BITS-DIM_BITS){1'b0}}, w};
		hx = {{(COORD_BITS-DIM_BITS){1'b0}}, h};
		return !px[COORD_BITS-1] && (px < wx) && !py[COORD_BITS-1] && (py < hx);
	endfunction

	logic [CFG_BITS-1:0]   width_q, height_q;
	logic [DIM_BITS-1:0]   eff_w, eff_h;

	logic signed [COORD_BITS-1:0] x_q, y_q, x2_q, y2_q;
	logic [COORD_BITS-1:0]        dx_q, dy_q;
	logic                         sx_neg_q, sy_neg_q;
	logic signed [ERR_BITS-1:0]   err_q;
	logic [COLOR_BITS-1:0]        color_q;

	logic [PIX_BITS-1:0]   pend_x_q, pend_y_q;
	logic [PIX_BITS-1:0]   out_x_q, out_y_q;
	logic [COLOR_BITS-1:0] out_color_q;
	logic                  out_last_q;

	logic signed [COORD_BITS:0] diff_x, diff_y;
	logic [COORD_BITS:0]        mag_x, mag_y;
	logic [COORD_BITS-1:0]      dx_init, dy_init;
	logic signed [ERR_BITS-1:0] err_init;

	logic signed [ERR_BITS:0]   e2, neg_dy, dx_ext;
	logic                       step_x, step_y;
	logic signed [ERR_BITS-1:0] err_next;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CFG_BITS'(MAX_DIM);
			height_q <= CFG_BITS'(MAX_DIM);
		end else if (cfg_we) begin
			if (cfg_addr == REG_IMAGE_WIDTH) begin
				width_q <= cfg_wdata;
			end else if (cfg_addr == REG_IMAGE_HEIGHT) begin
				height_q <= cfg_wdata;
			end
		end
	end

	// oversized image acts as the largest supported one
	assign eff_w = (width_q > CFG_BITS'(MAX_DIM)) ? DIM_BITS'(MAX_DIM) : width_q[DIM_BITS-1:0];
	assign eff_h = (height_q > CFG_BITS'(MAX_DIM)) ? DIM_BITS'(MAX_DIM) : height_q[DIM_BITS-1:0];

	// setup terms for a new line
	assign diff_x   = {end_x[COORD_BITS-1], end_x} - {start_x[COORD_BITS-1], start_x};
	assign diff_y   = {end_y[COORD_BITS-1], end_y} - {start_y[COORD_BITS-1], start_y};
	assign mag_x    = diff_x[COORD_BITS] ? -diff_x : diff_x;
	assign mag_y    = diff_y[COORD_BITS] ? -diff_y : diff_y;
	assign dx_init  = mag_x[COORD_BITS-1:0];
	assign dy_init  = mag_y[COORD_BITS-1:0];
	assign err_init = ERR_BITS'($signed({2'b00, dx_init})) - ERR_BITS'($signed({2'b00, dy_init}));

	// error rule for one step
	assign e2       = {err_q, 1'b0};
	assign dx_ext   = (ERR_BITS+1)'($signed({2'b00, dx_q}));
	assign neg_dy   = -((ERR_BITS+1)'($signed({2'b00, dy_q})));
	assign step_x   = e2 > neg_dy;
	assign step_y   = e2 < dx_ext;
	assign err_next = err_q - (step_x ? ERR_BITS'($signed({2'b00, dy_q})) : '0)
	                        + (step_y ? ERR_BITS'($signed({2'b00, dx_q})) : '0);

	// status back to the controller
	always_comb begin
		status.reject   = !in_image(start_x, start_y, eff_w, eff_h)
		               && !in_image(end_x, end_y, eff_w, eff_h);
		status.on_image = in_image(x_q, y_q, eff_w, eff_h);
		status.at_end   = (x_q == x2_q) && (y_q == y2_q);
	end

	// walk registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q      <= start_x;
			y_q      <= start_y;
			x2_q     <= end_x;
			y2_q     <= end_y;
			dx_q     <= dx_init;
			dy_q     <= dy_init;
			sx_neg_q <= !(start_x < end_x);
			sy_neg_q <= !(start_y < end_y);
			err_q    <= err_init;
			color_q  <= line_color;
		end else if (cmd.step) begin
			err_q <= err_next;
			if (step_x) begin
				x_q <= x_q + {{(COORD_BITS-1){sx_neg_q}}, 1'b1};
			end
			if (step_y) begin
				y_q <= y_q + {{(COORD_BITS-1){sy_neg_q}}, 1'b1};
			end
		end
	end

	// pending pixel, held back one point so the last one can be flagged
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			pend_x_q <= x_q[PIX_BITS-1:0];
			pend_y_q <= y_q[PIX_BITS-1:0];
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_x_q     <= pend_x_q;
			out_y_q     <= pend_y_q;
			out_color_q <= color_q;
			out_last_q  <= cmd.emit_last;
		end
	end

	assign pixel_x     = out_x_q;
	assign pixel_y     = out_y_q;
	assign pixel_color = out_color_q;
	assign last_pixel  = out_last_q;

endmodule

`default_nettype wire

>>> design/line_rasterizer.sv
// line_rasterizer: bresenham line walker, one pixel write per on-image point walked
// sequence: load in idle, walk up to max(|dx|,|dy|)+1 points, then flush the pending pixel
// the error loop takes one step per cycle unless an output stall holds the walk; a new line
// is taken only in idle; a line with neither endpoint on the image is dropped unwalked
// reset: state machine and output valid clear, image width and height return to MAX_DIM
// depends on lr_pkg, lr_ctrl, lr_datapath
`default_nettype none

module line_rasterizer import lr_pkg::*; #(
	parameter int unsigned MAX_DIM    = MAX_DIM_DEFAULT,
	parameter int unsigned COORD_BITS = COORD_BITS_DEFAULT,
	localparam int unsigned PIX_BITS  = $clog2(MAX_DIM)
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [CFG_IDX_BITS-1:0]      cfg_addr,
	input  wire logic [CFG_BITS-1:0]          cfg_wdata,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic signed [COORD_BITS-1:0] start_x,
	input  wire logic signed [COORD_BITS-1:0] start_y,
	input  wire logic signed [COORD_BITS-1:0] end_x,
	input  wire logic signed [COORD_BITS-1:0] end_y,
	input  wire logic [COLOR_BITS-1:0]        line_color,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic [PIX_BITS-1:0]               pixel_x,
	output logic [PIX_BITS-1:0]               pixel_y,
	output logic [COLOR_BITS-1:0]             pixel_color,
	output logic                              last_pixel
);

	lr_cmd_t    cmd;
	lr_status_t status;

	// controller
	lr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	// datapath
	lr_datapath #(
		.MAX_DIM    (MAX_DIM),
		.COORD_BITS (COORD_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_addr    (cfg_addr),
		.cfg_wdata   (cfg_wdata),
		.start_x     (start_x),
		.start_y     (start_y),
		.end_x       (end_x),
		.end_y       (end_y),
		.line_color  (line_color),
		.cmd         (cmd),
		.status      (status),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.pixel_color (pixel_color),
		.last_pixel  (last_pixel)
	);

endmodule

`default_nettype wire
